FILE: rtl/vsa_pkg.sv
// Shared constants, codes and control types of the voice slot allocator.
package vsa_pkg;

  localparam int NUM_VOICES_DEF = 32;
  localparam int MASK_W         = 32;
  localparam int IDX_OUT_W      = 5;
  localparam int PRIO_W         = 8;
  localparam int TICK_W         = 32;
  localparam int HANDLE_W       = 32;
  localparam int FUNC_W         = 2;

  localparam logic [FUNC_W-1:0] FUNC_ACQUIRE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_STOP_ALL = 2'd3;

  typedef struct packed {
    logic capture;
    logic finish_fast;
    logic scan_start;
    logic scan_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
  } sts_t;

endpackage

FILE: rtl/vsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/vsa_ctrl.sv
// Controller state machine of the voice slot allocator.
module vsa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  vsa_pkg::sts_t   sts,
  output vsa_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EVAL   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_TAIL   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.need_scan) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else begin
          cmd.finish_fast = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  a_scan_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_TAIL) |-> $past(state) == S_SCAN)
    else $error("tail entered without a scan");

endmodule

FILE: rtl/vsa_dp.sv
// Datapath of the voice slot allocator: slot table, scan compare and result registers.
module vsa_dp #(
  parameter int NUM_VOICES = vsa_pkg::NUM_VOICES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  vsa_pkg::cmd_t                       cmd,
  output vsa_pkg::sts_t                       sts,
  input  logic [vsa_pkg::FUNC_W-1:0]          func,
  input  logic [vsa_pkg::PRIO_W-1:0]          req_priority,
  input  logic [vsa_pkg::TICK_W-1:0]          req_start_tick,
  input  logic [vsa_pkg::HANDLE_W-1:0]        req_handle,
  input  logic                                req_streaming,
  input  logic [vsa_pkg::MASK_W-1:0]          stopped_mask,
  input  logic [vsa_pkg::MASK_W-1:0]          eos_mask,
  output logic                                done,
  output logic                                found,
  output logic [vsa_pkg::IDX_OUT_W-1:0]       slot_index,
  output logic                                was_stolen,
  output logic [vsa_pkg::MASK_W-1:0]          freed_mask
);

  localparam int IDX_W = $clog2(NUM_VOICES);
  localparam int REC_W = vsa_pkg::PRIO_W + vsa_pkg::TICK_W + vsa_pkg::HANDLE_W;

  // latched item
  logic [vsa_pkg::FUNC_W-1:0]   r_func;
  logic [vsa_pkg::PRIO_W-1:0]   r_prio;
  logic [vsa_pkg::TICK_W-1:0]   r_tick;
  logic [vsa_pkg::HANDLE_W-1:0] r_handle;
  logic                         r_stream;
  logic [NUM_VOICES-1:0]        r_stopped;
  logic [NUM_VOICES-1:0]        r_eos;

  // slot state kept in flops
  logic [NUM_VOICES-1:0] active;
  logic [NUM_VOICES-1:0] streaming;

  // scan
  logic [IDX_W-1:0]          cnt;
  logic                      rd_vld;
  logic [IDX_W-1:0]          rd_idx;
  logic                      have;
  logic [IDX_W-1:0]          best_idx;
  logic [vsa_pkg::PRIO_W-1:0] best_prio;
  logic [vsa_pkg::TICK_W-1:0] best_tick;

  // result
  logic                  res_found;
  logic [IDX_W-1:0]      res_idx;
  logic                  res_stolen;
  logic [NUM_VOICES-1:0] res_freed;

  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  logic [REC_W-1:0]            ram_wdata;
  logic [REC_W-1:0]            ram_rdata;
  logic [vsa_pkg::PRIO_W-1:0]  rd_prio;
  logic [vsa_pkg::TICK_W-1:0]  rd_tick;
  logic [vsa_pkg::HANDLE_W-1:0] rd_handle;

  logic                  free_any;
  logic [IDX_W-1:0]      free_idx;
  logic [NUM_VOICES-1:0] upd_free;
  logic                  take;
  logic                  is_acq;
  logic                  do_write;
  logic [NUM_VOICES-1:0] one_hot;

  vsa_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_VOICES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (cnt),
    .rd_data (ram_rdata)
  );

  assign {rd_prio, rd_tick, rd_handle} = ram_rdata;

  always_comb begin
    free_idx = '0;
    for (int i = NUM_VOICES - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign free_any = ~&active;
  assign is_acq   = (r_func == vsa_pkg::FUNC_ACQUIRE);
  assign upd_free = active & r_stopped & (~streaming | r_eos);

  assign sts.need_scan = (r_func == vsa_pkg::FUNC_LOOKUP) || (is_acq && !free_any);
  assign sts.scan_last = (cnt == IDX_W'(NUM_VOICES - 1));

  always_comb begin
    take = 1'b0;
    if (rd_vld && active[rd_idx]) begin
      if (is_acq) begin
        take = (rd_prio < r_prio) &&
               (!have || rd_prio < best_prio ||
                (rd_prio == best_prio && rd_tick < best_tick));
      end else begin
        take = !have && (r_handle != '0) && (rd_handle == r_handle);
      end
    end
  end

  // acquire writes the granted slot, either at once or after the steal scan
  assign do_write  = is_acq && ((cmd.finish_fast && free_any) || (cmd.commit && have));
  assign ram_we    = do_write;
  assign ram_waddr = cmd.commit ? best_idx : free_idx;
  assign ram_wdata = {r_prio, r_tick, r_handle};
  assign one_hot   = {{(NUM_VOICES-1){1'b0}}, 1'b1} << best_idx;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_func    <= func;
      r_prio    <= req_priority;
      r_tick    <= req_start_tick;
      r_handle  <= req_handle;
      r_stream  <= req_streaming;
      r_stopped <= stopped_mask[NUM_VOICES-1:0];
      r_eos     <= eos_mask[NUM_VOICES-1:0];
    end
    rd_idx <= cnt;
    if (take) begin
      best_idx  <= rd_idx;
      best_prio <= rd_prio;
      best_tick <= rd_tick;
    end
    if (do_write) begin
      streaming[ram_waddr] <= r_stream;
    end
    if (cmd.finish_fast) begin
      res_found  <= is_acq;
      res_idx    <= is_acq ? free_idx : '0;
      res_stolen <= 1'b0;
      unique case (r_func)
        vsa_pkg::FUNC_UPDATE:   res_freed <= upd_free;
        vsa_pkg::FUNC_STOP_ALL: res_freed <= active;
        default:                res_freed <= '0;
      endcase
    end
    if (cmd.commit) begin
      res_found  <= have;
      res_idx    <= have ? best_idx : '0;
      res_stolen <= have && is_acq;
      res_freed  <= (have && is_acq) ? one_hot : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      cnt    <= '0;
      rd_vld <= 1'b0;
      have   <= 1'b0;
      done   <= 1'b0;
    end else begin
      done   <= cmd.finish_fast | cmd.commit;
      rd_vld <= cmd.scan_step;
      if (cmd.scan_start) begin
        cnt  <= '0;
        have <= 1'b0;
      end else if (cmd.scan_step) begin
        cnt <= sts.scan_last ? '0 : cnt + 1'b1;
      end
      if (take) begin
        have <= 1'b1;
      end
      if (cmd.finish_fast) begin
        unique case (r_func)
          vsa_pkg::FUNC_UPDATE:   active <= active & ~upd_free;
          vsa_pkg::FUNC_STOP_ALL: active <= '0;
          default:                ;
        endcase
      end
      if (do_write) begin
        active[ram_waddr] <= 1'b1;
      end
    end
  end

  assign found      = res_found;
  assign slot_index = vsa_pkg::IDX_OUT_W'(res_idx);
  assign was_stolen = res_stolen;
  assign freed_mask = vsa_pkg::MASK_W'(res_freed);

  a_stolen_found: assert property (@(posedge clk) disable iff (rst)
    (done && was_stolen) |-> found && $onehot(res_freed))
    else $error("steal without a single granted slot");

  a_grant_active: assert property (@(posedge clk) disable iff (rst)
    (done && found && r_func == vsa_pkg::FUNC_ACQUIRE) |-> active[res_idx])
    else $error("granted slot not marked active");

  a_freed_cleared: assert property (@(posedge clk) disable iff (rst)
    (done && !was_stolen) |-> (res_freed & active) == '0)
    else $error("freed slot still active");

  a_steal_when_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && have && is_acq) |-> &active)
    else $error("steal taken while a slot was free");

endmodule

FILE: rtl/voice_slot_allocator_top.sv
// Top level of the voice slot allocator.
//
// An item is taken when start is high and busy is low; its single result appears on
// found, slot_index, was_stolen and freed_mask for one cycle with done high, and the
// receiver must take it then. Update, stop-all and an acquire that finds a free slot
// finish without a scan of the table. Lookup and an acquire on a full table read the
// slot table one entry a cycle through the single read port of the table RAM, and then
// pass through the TAIL and COMMIT states. busy falls as the result is registered,
// so a new item may be started in the cycle that done is shown. Slot fields are only
// read for active slots; the table RAM needs no clearing after reset.
module voice_slot_allocator_top #(
  parameter int NUM_VOICES = vsa_pkg::NUM_VOICES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [vsa_pkg::FUNC_W-1:0]    func,
  input  logic [vsa_pkg::PRIO_W-1:0]    req_priority,
  input  logic [vsa_pkg::TICK_W-1:0]    req_start_tick,
  input  logic [vsa_pkg::HANDLE_W-1:0]  req_handle,
  input  logic                          req_streaming,
  input  logic [vsa_pkg::MASK_W-1:0]    stopped_mask,
  input  logic [vsa_pkg::MASK_W-1:0]    eos_mask,
  output logic                          done,
  output logic                          found,
  output logic [vsa_pkg::IDX_OUT_W-1:0] slot_index,
  output logic                          was_stolen,
  output logic [vsa_pkg::MASK_W-1:0]    freed_mask
);

  vsa_pkg::cmd_t cmd;
  vsa_pkg::sts_t sts;

  vsa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  vsa_dp #(
    .NUM_VOICES (NUM_VOICES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .func           (func),
    .req_priority   (req_priority),
    .req_start_tick (req_start_tick),
    .req_handle     (req_handle),
    .req_streaming  (req_streaming),
    .stopped_mask   (stopped_mask),
    .eos_mask       (eos_mask),
    .done           (done),
    .found          (found),
    .slot_index     (slot_index),
    .was_stolen     (was_stolen),
    .freed_mask     (freed_mask)
  );

endmodule
